// ===== hw/rtl/pqd_pkg.sv =====
// shared types and codes for the process queue with delete
// no dependencies; every other file imports this package
package pqd_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int PRIO_W = 8;
  localparam int PID_W  = 22;
  localparam int RUN_W  = 16;
  localparam int OCC_W  = 5;

  // request modes
  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [PID_W-1:0]  pid;
    logic [RUN_W-1:0]  runtime;
  } record_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PRIO_W-1:0] prio;
    logic [PID_W-1:0]  pid;
    logic [RUN_W-1:0]  runtime;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

endpackage

// ===== hw/rtl/pqd_if.sv =====
// valid/ready channel interfaces for requests and results
// depends on pqd_pkg for field widths
interface pqd_cmd_if import pqd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [PRIO_W-1:0] entry_priority;
  logic [PID_W-1:0]  pid_value;
  logic [RUN_W-1:0]  entry_runtime;

  modport source (output valid, mode, entry_priority, pid_value, entry_runtime, input ready);
  modport sink (input valid, mode, entry_priority, pid_value, entry_runtime, output ready);
endinterface

interface pqd_rsp_if import pqd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [PRIO_W-1:0] out_priority;
  logic [PID_W-1:0]  out_pid;
  logic [RUN_W-1:0]  out_runtime;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, status, out_priority, out_pid, out_runtime, occupancy,
                  input ready);
  modport sink (input valid, status, out_priority, out_pid, out_runtime, occupancy,
                output ready);
endinterface

// ===== hw/rtl/pqd_store.sv =====
// record memory: one write port, one read port, registered read data
// depends on pqd_pkg for record_t
module pqd_store import pqd_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  record_t       wdata,
  input  logic [AW-1:0] raddr,
  output record_t       rdata
);

  record_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pqd_ctrl.sv =====
// sequencer: circular-buffer pointers, push/pop/scan/shift over the record memory
// depends on pqd_pkg and the command interface in pqd_if
module pqd_ctrl import pqd_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  pqd_cmd_if.sink       cmd,
  output logic          we,
  output logic [AW-1:0] waddr,
  output record_t       wdata,
  output logic [AW-1:0] raddr,
  input  record_t       rdata,
  output logic          res_valid,
  input  logic          res_ready,
  output result_t       res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state, state_next;
  logic [AW-1:0]    head, head_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    idx, idx_next;
  logic [PID_W-1:0] key, key_next;
  result_t          res_next;
  logic [CW-1:0]    idx_inc;
  logic [CW-1:0]    count_dec;

  // logical position to memory address, head-relative with one wrap
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] pos);
    logic [CW:0] s;
    s = (CW+1)'(hd) + (CW+1)'(pos);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign idx_inc   = idx + CW'(1);
  assign count_dec = count - CW'(1);
  assign cmd.ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    idx_next   = idx;
    key_next   = key;
    res_next   = res;
    we         = 1'b0;
    waddr      = phys(head, count);
    wdata      = rdata;
    raddr      = phys(head, idx_inc);

    unique case (state)
      S_IDLE: begin
        raddr = head;
        if (cmd.valid) begin
          res_next           = '0;
          res_next.status    = ST_DONE;
          res_next.occupancy = OCC_W'(count);
          idx_next           = '0;
          key_next           = cmd.pid_value;
          state_next         = S_DONE;
          case (cmd.mode)
            MODE_PUSH: begin
              if (count == CW'(DEPTH)) begin
                res_next.status = ST_FULL;
              end else begin
                we                 = 1'b1;
                wdata.prio         = cmd.entry_priority;
                wdata.pid          = cmd.pid_value;
                wdata.runtime      = cmd.entry_runtime;
                count_next         = count + CW'(1);
                res_next.occupancy = OCC_W'(count + CW'(1));
              end
            end
            MODE_POP: begin
              if (count == '0) begin
                res_next.status = ST_MISS;
              end else begin
                state_next = S_POP;
              end
            end
            MODE_DEL: begin
              if (count == '0) begin
                res_next.status = ST_MISS;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_POP: begin
        res_next.prio      = rdata.prio;
        res_next.pid       = rdata.pid;
        res_next.runtime   = rdata.runtime;
        res_next.occupancy = OCC_W'(count_dec);
        head_next          = phys(head, CW'(1));
        count_next         = count_dec;
        state_next         = S_DONE;
      end
      S_SCAN: begin
        // rdata holds entry idx; the read of idx+1 goes out in the same cycle
        if (rdata.pid == key) begin
          res_next.prio    = rdata.prio;
          res_next.pid     = rdata.pid;
          res_next.runtime = rdata.runtime;
          state_next       = S_SHIFT;
        end else if (idx_inc < count) begin
          idx_next = idx_inc;
        end else begin
          res_next.status = ST_MISS;
          state_next      = S_DONE;
        end
      end
      S_SHIFT: begin
        // rdata holds entry idx+1, moved down into idx
        if (idx_inc < count) begin
          we       = 1'b1;
          waddr    = phys(head, idx);
          wdata    = rdata;
          raddr    = phys(head, idx + CW'(2));
          idx_next = idx_inc;
        end else begin
          count_next         = count_dec;
          res_next.occupancy = OCC_W'(count_dec);
          state_next         = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
    idx <= idx_next;
    key <= key_next;
    res <= res_next;
  end

endmodule

// ===== hw/rtl/pqd_outreg.sv =====
// result output register between the sequencer and the result channel
// depends on pqd_pkg and pqd_rsp_if
module pqd_outreg import pqd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     res_valid,
  output logic     res_ready,
  input  result_t  res,
  pqd_rsp_if.source rsp
);

  result_t held;

  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

  assign rsp.status       = held.status;
  assign rsp.out_priority = held.prio;
  assign rsp.out_pid      = held.pid;
  assign rsp.out_runtime  = held.runtime;
  assign rsp.occupancy    = held.occupancy;

endmodule

// ===== hw/rtl/process_queue_with_delete_unit.sv =====
// top level of the process queue with delete-by-id
// depends on pqd_pkg, pqd_if, pqd_store, pqd_ctrl, pqd_outreg
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+---------------------------------------------
//   cmd     | in  | cmd.valid/ready   | mode, entry_priority, pid_value, entry_runtime
//   rsp     | out | rsp.valid/ready   | status, out_priority, out_pid, out_runtime,
//           |     |                   | occupancy
//
// a push writes in the idle state, a pop reads the head record in its pop state, and a delete
// scans then shifts (one memory read per record scanned, one read/write per record moved down,
// all through the single read and single write port of the record memory)
// one request is in work at a time; the next is taken while a result waits in the output register
// reset: synchronous, clears the queue to empty; memory contents are not cleared
// a stalled rsp holds the result and the sequencer waits in its done state

module process_queue_with_delete_unit import pqd_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  pqd_cmd_if.sink   cmd,
  pqd_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);

  // record memory port
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  record_t       wdata;
  record_t       rdata;

  // finished result toward the output register
  logic    res_valid;
  logic    res_ready;
  result_t res;

  pqd_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer: head pointer, count, scan and gap closing
  pqd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register decouples the result channel from the sequencer
  pqd_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rsp       (rsp)
  );

endmodule

// ===== hw/rtl/pqd_checker.sv =====
// port-level checks for the process queue with delete
// depends on pqd_pkg; bound to process_queue_with_delete_unit
module pqd_checker import pqd_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [1:0]        status,
  input logic [PRIO_W-1:0] out_priority,
  input logic [PID_W-1:0]  out_pid,
  input logic [RUN_W-1:0]  out_runtime,
  input logic [OCC_W-1:0]  occupancy
);

  // a full status only comes with a full queue
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FULL) |-> occupancy == OCC_W'(DEPTH))
    else $error("full status with queue not full");

  // a miss or full result carries a zero record
  a_zero_rec: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_DONE) |-> (out_priority == '0 && out_pid == '0 &&
                                          out_runtime == '0))
    else $error("record data on a miss or full result");

  // occupancy never above the depth (checked only for a depth of 31 or less)
  a_occ_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (DEPTH > 31 || occupancy <= OCC_W'(DEPTH)))
    else $error("occupancy above depth");

  // one request in work at a time
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("request taken while another is in work");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(out_pid) &&
                                   $stable(occupancy)))
    else $error("stalled result changed");

endmodule

bind process_queue_with_delete_unit pqd_checker #(.DEPTH(DEPTH)) u_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .out_priority (rsp.out_priority),
  .out_pid      (rsp.out_pid),
  .out_runtime  (rsp.out_runtime),
  .occupancy    (rsp.occupancy)
);
